[rtl/signed_window_scalar_recoder_unit_defines.svh]
// ---------------------------------------------------------------------------
// signed window scalar recoder assertion macros
// shared concurrent assertion forms; each expects clk and rst_n in scope
// ---------------------------------------------------------------------------
`ifndef SIGNED_WINDOW_SCALAR_RECODER_UNIT_DEFINES_SVH
`define SIGNED_WINDOW_SCALAR_RECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define SWR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swr_pkg.sv]
// ---------------------------------------------------------------------------
// swr_pkg
// shared constants and types of the signed window scalar recoder
// ---------------------------------------------------------------------------
package swr_pkg;

  // scalar framing
  localparam int SCALAR_BYTES = 32;
  localparam int BYTE_CNT_W   = (SCALAR_BYTES > 1) ? $clog2(SCALAR_BYTES) : 1;
  localparam int BYTE_BITS    = 8;

  // recoding datapath
  localparam int BUF_W      = 23;
  localparam int HELD_W     = 5;
  localparam int DIGIT_W    = 16;
  localparam int WIN_W      = 5;
  localparam int MAX_DIGITS = 4;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

  // window width limits
  localparam logic [WIN_W-1:0] W_MIN   = 5'd2;
  localparam logic [WIN_W-1:0] W_MAX   = 5'd16;
  localparam logic [WIN_W-1:0] W_RESET = 5'd4;

  // byte queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  // one queued byte and its end-of-scalar mark
  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } q_item_t;

  // active window setting
  typedef struct packed {
    logic [WIN_W-1:0]   width;
    logic [DIGIT_W-1:0] mask;
  } win_cfg_t;

endpackage

[rtl/swr_queue.sv]
// ---------------------------------------------------------------------------
// swr_queue
// small byte queue that decouples the front from the recoding back end
// ---------------------------------------------------------------------------
module swr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             push,
  input  swr_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output swr_pkg::q_item_t head_item
);
  import swr_pkg::*;

  q_item_t              entry_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  // status
  assign full       = (count_r == (Q_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(do_pop);
    count_nxt  = count_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/swr_front.sv]
// ---------------------------------------------------------------------------
// swr_front
// accepts scalar bytes, counts them and marks the final byte of each scalar
// ---------------------------------------------------------------------------
module swr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            clr,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [swr_pkg::BYTE_BITS-1:0]   in_scalar_byte,
  input  logic                            q_full,
  output logic                            q_push,
  output swr_pkg::q_item_t                q_item
);
  import swr_pkg::*;

  logic [BYTE_CNT_W-1:0] bytes_taken_r, bytes_taken_nxt;
  logic                  is_last;

  // accept while the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify the transaction
  assign is_last        = (bytes_taken_r == BYTE_CNT_W'(SCALAR_BYTES - 1));
  assign q_item.data    = in_scalar_byte;
  assign q_item.last    = is_last;

  always_comb begin
    bytes_taken_nxt = bytes_taken_r;
    if (q_push) begin
      bytes_taken_nxt = is_last ? '0 : bytes_taken_r + BYTE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      bytes_taken_r <= '0;
    end else begin
      bytes_taken_r <= bytes_taken_nxt;
    end
  end

endmodule

[rtl/swr_back.sv]
// ---------------------------------------------------------------------------
// swr_back
// bit buffer and recoding engine, one signed digit at a time into the output
// register, held while out_stall keeps a waiting digit in that register
// ---------------------------------------------------------------------------
module swr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clr,
  input  swr_pkg::win_cfg_t                   win,
  input  logic                                q_valid,
  input  swr_pkg::q_item_t                    q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swr_pkg::DIGIT_W-1:0]  out_signed_digit,
  output logic                                out_last_digit
);
  import swr_pkg::*;

  // stream state
  logic [BUF_W-1:0]   bitbuf_r, bitbuf_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic               carry_r, carry_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               last_r, last_nxt;
  logic               busy_r, busy_nxt;

  // output register
  logic               out_valid_r;
  logic [DIGIT_W-1:0] out_digit_r;
  logic               out_last_r;

  logic               has_full, has_part, emit, can_emit, blocked;
  logic               more, done, flag, free;
  logic [DIGIT_W-1:0] chunk, val, digit;
  logic [DIGIT_W:0]   sum;
  logic [3:0]         top_idx;
  logic               sign_bit, ovf, carry_new;
  logic [HELD_W-1:0]  rem_held;
  logic [BUF_W-1:0]   shifted, merged;
  logic [CNT_W-1:0]   cnt_inc;
  logic [BUF_W-1:0]   post_buf;
  logic [HELD_W-1:0]  post_held;
  logic               post_carry;
  logic [CNT_W-1:0]   post_cnt;
  logic               digit_ok, idle_ok, last_fire;

  // what the current byte still owes
  assign has_full = busy_r && (held_r >= win.width) && (cnt_r < CNT_W'(MAX_DIGITS));
  assign has_part = busy_r && !has_full && last_r && (held_r != '0)
                    && (cnt_r < CNT_W'(MAX_DIGITS));
  assign emit     = has_full || has_part;
  assign can_emit = !out_valid_r || !out_stall;
  assign blocked  = emit && !can_emit;

  // recode the low chunk with the pending carry
  assign chunk     = bitbuf_r[DIGIT_W-1:0] & win.mask;
  assign sum       = {1'b0, chunk} + {{DIGIT_W{1'b0}}, carry_r};
  assign val       = sum[DIGIT_W-1:0] & win.mask;
  assign top_idx   = 4'(win.width - 5'd1);
  assign sign_bit  = val[top_idx];
  assign ovf       = sum[win.width];
  assign digit     = val | (sign_bit ? ~win.mask : '0);
  assign carry_new = ovf || sign_bit;

  // state after a full digit
  assign rem_held = held_r - win.width;
  assign shifted  = bitbuf_r >> win.width;
  assign cnt_inc  = cnt_r + CNT_W'(1);

  // another digit follows from this byte
  assign more = has_full && (cnt_inc < CNT_W'(MAX_DIGITS))
                && ((rem_held >= win.width) || (last_r && (rem_held != '0)));
  assign done = busy_r && !blocked && !more;
  assign flag = last_r && !more;
  assign free = !busy_r || done;
  assign q_pop = free && q_valid;

  // state once this cycle's digit is out
  always_comb begin
    post_buf   = bitbuf_r;
    post_held  = held_r;
    post_carry = carry_r;
    post_cnt   = cnt_r;
    if (has_full && !blocked) begin
      post_buf   = shifted;
      post_held  = rem_held;
      post_carry = carry_new;
      post_cnt   = cnt_inc;
    end
    if (done && last_r) begin
      post_buf   = '0;
      post_held  = '0;
      post_carry = 1'b0;
    end
  end

  // fold the next byte in above the held bits
  assign merged = post_buf | (BUF_W'(q_head.data) << post_held[3:0]);

  always_comb begin
    bitbuf_nxt = post_buf;
    held_nxt   = post_held;
    carry_nxt  = post_carry;
    cnt_nxt    = post_cnt;
    last_nxt   = last_r;
    busy_nxt   = busy_r && !done;
    if (q_pop) begin
      bitbuf_nxt = merged;
      held_nxt   = post_held + HELD_W'(BYTE_BITS);
      cnt_nxt    = '0;
      last_nxt   = q_head.last;
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      bitbuf_r <= '0;
      held_r   <= '0;
      carry_r  <= 1'b0;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      busy_r   <= 1'b0;
    end else begin
      bitbuf_r <= bitbuf_nxt;
      held_r   <= held_nxt;
      carry_r  <= carry_nxt;
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
      busy_r   <= busy_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && can_emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && can_emit) begin
      out_digit_r <= digit;
      out_last_r  <= flag;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_signed_digit = out_digit_r;
  assign out_last_digit   = out_last_r;

  // checks
  assign digit_ok  = ((out_digit_r | win.mask) == '1) || ((out_digit_r & ~win.mask) == '0);
  assign idle_ok   = (held_r < win.width);
  assign last_fire = emit && can_emit && flag;

`include "signed_window_scalar_recoder_unit_defines.svh"

  `SWR_ASSERT_NOW(a_digit_in_window, out_valid_r, digit_ok, "digit outside signed window")
  `SWR_ASSERT_NOW(a_idle_below_width, !busy_r, idle_ok, "full chunk left in idle buffer")
  `SWR_ASSERT_NEXT(a_carry_clear_after_last, last_fire, !carry_r, "carry survived end of scalar")

endmodule

[rtl/signed_window_scalar_recoder_unit.sv]
// ---------------------------------------------------------------------------
// signed_window_scalar_recoder_unit
// signed fixed-window recoding of a byte-serial scalar into signed digits
// ---------------------------------------------------------------------------
// A scalar of SCALAR_BYTES bytes (32) enters least significant byte first,
// one byte per input transaction; out come ceil(8*SCALAR_BYTES/w) signed
// digits in -2^(w-1)..2^(w-1)-1, least significant first, the final one
// flagged by out_last_digit and the final carry dropped. The window width w
// is written through cfg_window_bits (values below 2 act as 2, above 16 as
// 16); a write also restarts the scalar and is taken in the same cycle,
// cfg_ready being always high. Bytes pass through a four-entry queue into
// the recoding engine, which emits a byte's digits one after another and
// pulls the next byte during the cycle of a byte's last digit, or during
// the cycle in which it handles a byte that yields no digit. A digit that
// cannot enter the output register while out_stall holds a valid digit
// stalls the engine. No clearing pass after reset.
// ---------------------------------------------------------------------------
module signed_window_scalar_recoder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [swr_pkg::BYTE_BITS-1:0]       in_scalar_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [swr_pkg::DIGIT_W-1:0]  out_signed_digit,
  output logic                                out_last_digit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swr_pkg::WIN_W-1:0]           cfg_window_bits
);
  import swr_pkg::*;

  win_cfg_t         win_r, win_nxt;
  logic             cfg_wr;
  logic [WIN_W-1:0] w_eff;
  logic             q_full, q_push, q_pop, q_valid;
  q_item_t          q_in, q_head;

  // window register, clamped on write
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (cfg_window_bits < W_MIN) begin
      w_eff = W_MIN;
    end else if (cfg_window_bits > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = cfg_window_bits;
    end
    win_nxt.width = w_eff;
    win_nxt.mask  = ~({DIGIT_W{1'b1}} << w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.width <= W_RESET;
      win_r.mask  <= ~({DIGIT_W{1'b1}} << W_RESET);
    end else if (cfg_wr) begin
      win_r <= win_nxt;
    end
  end

  // byte intake and classification
  swr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .clr            (cfg_wr),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scalar_byte (in_scalar_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_in)
  );

  // decoupling queue
  swr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (cfg_wr),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  // recoding engine and output register
  swr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clr              (cfg_wr),
    .win              (win_r),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_signed_digit (out_signed_digit),
    .out_last_digit   (out_last_digit)
  );

endmodule
